// ===== design/dsobel_pkg.sv =====
`default_nettype none

package dsobel_pkg;

    // Line store depth and the derived column counter width
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Field and register widths
    localparam int PIX_W   = 8;
    localparam int CFG_W_W = 11;
    localparam int CFG_H_W = 12;
    localparam int ROW_W   = 12;
    localparam int APB_DW  = 32;
    localparam int ADDR_W  = 3;

    // Gradient arithmetic
    localparam int SUM_W     = 12;
    localparam int MAG_W     = 11;
    localparam int WS_W      = 4;
    localparam int DSR_W     = 3;
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Register index (paddr[2]) and request kinds
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam logic REQ_DRAIN  = 1'b1;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic signed [2:0]        t_wgt;
    typedef t_wgt                     t_kern [3][3];
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [WS_W-1:0]   t_wsum;

    // Weights indexed [dx+1][dy+1]
    localparam t_kern KERN_45 = '{
        '{ 3'sd0,  3'sd1, 3'sd2},
        '{-3'sd1,  3'sd0, 3'sd1},
        '{-3'sd2, -3'sd1, 3'sd0}
    };
    localparam t_kern KERN_135 = '{
        '{-3'sd2, -3'sd1, 3'sd1},
        '{-3'sd1,  3'sd0, 3'sd1},
        '{ 3'sd0,  3'sd1, 3'sd2}
    };

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_SHIFT = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ===== design/dsobel_ram.sv =====
`default_nettype none

module dsobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/diagonal_sobel_3x3_edge.sv =====
`default_nettype none
// Sequence: a request that releases a result passes the shift, sum, divide and output
// states to m_axis_tvalid, dividing in the 11-step bit-serial divider. No new request
// is taken before idle again; a request without a result only shifts, and the first
// drain of a frame may make an extra pass through the line stores.
// Reset: synchronous, active low; clears counters, FSM and output valid flag, sets the
// frame to 640 x 480. The line stores are not cleared and need no clearing pass.

module diagonal_sobel_3x3_edge (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // pixel request stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [dsobel_pkg::PIX_W-1:0] s_axis_tdata,  // [7:0] pixel_value
    input  wire logic                         s_axis_tuser,  // [0] req_type
    // edge result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [dsobel_pkg::PIX_W-1:0] m_axis_tdata,  // [7:0] edge_value
    output logic                              m_axis_tlast,  // frame_last
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dsobel_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dsobel_pkg::APB_DW-1:0] pwdata,
    output logic      [dsobel_pkg::APB_DW-1:0] prdata,
    output logic                               pready
);

    import dsobel_pkg::*;

    // Configuration
    logic [CFG_W_W-1:0] r_cfg_width;
    logic [CFG_H_W-1:0] r_cfg_height;
    logic               cfg_wr;
    logic [COL_W-1:0]   w_last;   // last column index of the effective width
    logic [ROW_W-1:0]   h_last;   // last row index of the effective height

    // Control
    t_state             r_state;
    t_state             n_state;
    logic               r_done;   // whole frame received, arrivals now virtual
    logic               r_real;   // current arrival carries a real pixel
    t_pix               r_pix;
    logic [COL_W-1:0]   r_in_col;
    logic [ROW_W:0]     r_in_row; // runs one past the frame for the flush rows
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic [STEP_W-1:0]  r_step;
    logic               s_acc;
    logic               arrival_emits;
    logic               in_row_end;

    // Line stores and window
    t_pix               upper_q;
    t_pix               middle_q;
    logic               ram_we;
    t_pix               r_win [3][3];    // [column: left, center, right][row: top..bottom]

    // Gradients and divider
    t_sum               s45;
    t_sum               s135;
    t_wsum              ws45;
    t_wsum              ws135;
    logic [2:0]         col_ok;
    logic [2:0]         row_ok;
    logic [MAG_W-1:0]   r_quo [2];
    logic [DSR_W-1:0]   r_rem [2];
    logic [DSR_W-1:0]   r_dsr [2];
    logic [MAG_W-1:0]   n_quo [2];
    logic [DSR_W-1:0]   n_rem [2];
    logic [MAG_W-1:0]   mag [2];
    logic [DSR_W-1:0]   dsr [2];
    logic [MAG_W:0]     grad_sum;
    logic               out_last;
    logic               out_free;

    // Output register
    logic               r_out_valid;
    t_pix               r_out_edge;
    logic               r_out_last;

    // ---------------------------------------------------------------------
    // Register port: index is paddr[2], low address bits are ignored.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_cfg_width);
            REG_HEIGHT: prdata = APB_DW'(r_cfg_height);
            default:    prdata = '0;
        endcase
    end

    // Clamp the frame size: zero acts as one, width saturates at the store depth.
    always_comb begin
        if (r_cfg_width == '0) begin
            w_last = '0;
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(r_cfg_width - 1'b1);
        end
        h_last = (r_cfg_height == '0) ? '0 : r_cfg_height - 1'b1;
    end

    // ---------------------------------------------------------------------
    // Line stores: read at the input column every cycle, write back at the
    // same column in the shift state of a real pixel. upper gets the old middle
    // row, middle gets the arriving pixel. Requests are handled one at a time,
    // so a read never overlaps a pending write to the same column.
    // ---------------------------------------------------------------------
    assign ram_we = (r_state == ST_SHIFT) && r_real;

    dsobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_in_col),
        .i_wdata (middle_q),
        .i_raddr (r_in_col),
        .o_rdata (upper_q)
    );

    dsobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_in_col),
        .i_wdata (r_pix),
        .i_raddr (r_in_col),
        .o_rdata (middle_q)
    );

    // ---------------------------------------------------------------------
    // Arrival bookkeeping. The result for a pixel leaves once the pixel one
    // row down and one column right has arrived (width + 1 arrivals later).
    // After the frame, drains feed virtual arrivals that flush the last row.
    // ---------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_row_end    = (r_in_col == w_last);
    assign arrival_emits = (r_in_row >= (ROW_W+1)'(2))
                        || ((r_in_row == (ROW_W+1)'(1)) && (r_in_col != '0));

    // ---------------------------------------------------------------------
    // Kernel sums over the window; taps outside the frame are skipped.
    // ---------------------------------------------------------------------
    always_comb begin
        col_ok = {r_out_col != w_last, 1'b1, r_out_col != '0};
        row_ok = {r_out_row != h_last, 1'b1, r_out_row != '0};
        s45   = '0;
        s135  = '0;
        ws45  = '0;
        ws135 = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (col_ok[i] && row_ok[j]) begin
                    s45   = s45  + t_sum'($signed({1'b0, r_win[i][j]})) * t_sum'(KERN_45[i][j]);
                    s135  = s135 + t_sum'($signed({1'b0, r_win[i][j]})) * t_sum'(KERN_135[i][j]);
                    ws45  = ws45  + t_wsum'(KERN_45[i][j]);
                    ws135 = ws135 + t_wsum'(KERN_135[i][j]);
                end
            end
        end
        // Only |sum / wsum| is needed: divide magnitudes, a zero weight sum divides by one.
        mag[0] = s45[SUM_W-1]  ? MAG_W'(-s45)  : MAG_W'(s45);
        mag[1] = s135[SUM_W-1] ? MAG_W'(-s135) : MAG_W'(s135);
        dsr[0] = ws45[WS_W-1]  ? DSR_W'(-ws45)  : DSR_W'(ws45);
        dsr[1] = ws135[WS_W-1] ? DSR_W'(-ws135) : DSR_W'(ws135);
        for (int l = 0; l < 2; l++) begin
            if (dsr[l] == '0) begin
                dsr[l] = DSR_W'(1);
            end
        end
    end

    // One restoring step per cycle, both kernels side by side.
    always_comb begin
        logic [DSR_W:0] trial;
        for (int l = 0; l < 2; l++) begin
            trial = {r_rem[l], r_quo[l][MAG_W-1]};
            if (trial >= {1'b0, r_dsr[l]}) begin
                n_rem[l] = DSR_W'(trial - {1'b0, r_dsr[l]});
                n_quo[l] = {r_quo[l][MAG_W-2:0], 1'b1};
            end else begin
                n_rem[l] = trial[DSR_W-1:0];
                n_quo[l] = {r_quo[l][MAG_W-2:0], 1'b0};
            end
        end
    end

    assign grad_sum = {1'b0, r_quo[0]} + {1'b0, r_quo[1]};
    assign out_last = (r_out_col == w_last) && (r_out_row == h_last);
    assign out_free = !r_out_valid || m_axis_tready;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc && (r_done || (s_axis_tuser != REQ_DRAIN))) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_READ:  n_state = ST_SHIFT;
            ST_SHIFT: begin
                if (arrival_emits) begin
                    n_state = ST_SUM;
                end else if (r_real) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_READ;   // a drain owes a result: advance one more column
                end
            end
            ST_SUM:   n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_width  <= CFG_W_W'(640);
            r_cfg_height <= CFG_H_W'(480);
            r_done       <= 1'b0;
            r_real       <= 1'b0;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    // hold the pixel; a drain before the frame is complete is dropped
                    r_real <= !r_done;
                    r_pix  <= s_axis_tdata;
                end
                ST_SHIFT: begin
                    // advance the window by one column
                    for (int j = 0; j < 3; j++) begin
                        r_win[0][j] <= r_win[1][j];
                        r_win[1][j] <= r_win[2][j];
                    end
                    r_win[2][0] <= upper_q;
                    r_win[2][1] <= middle_q;
                    r_win[2][2] <= r_pix;
                    if (in_row_end) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + 1'b1;
                        if (r_real && (r_in_row == {1'b0, h_last})) begin
                            r_done <= 1'b1;
                        end
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
                ST_SUM: begin
                    for (int l = 0; l < 2; l++) begin
                        r_quo[l] <= mag[l];
                        r_dsr[l] <= dsr[l];
                        r_rem[l] <= '0;
                    end
                    r_step <= '0;
                end
                ST_DIV: begin
                    for (int l = 0; l < 2; l++) begin
                        r_quo[l] <= n_quo[l];
                        r_rem[l] <= n_rem[l];
                    end
                    r_step <= r_step + 1'b1;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_edge  <= grad_sum[PIX_W:1];
                        r_out_last  <= out_last;
                        if (out_last) begin
                            // frame complete: start over with the next pixel
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                            r_done    <= 1'b0;
                        end else if (r_out_col == w_last) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + 1'b1;
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            // A register write abandons the frame in progress.
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_WIDTH:  r_cfg_width  <= pwdata[CFG_W_W-1:0];
                    REG_HEIGHT: r_cfg_height <= pwdata[CFG_H_W-1:0];
                    default: ;
                endcase
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_done    <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_edge;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== design/dsobel_chk.sv =====
`default_nettype none

module dsobel_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic                         s_axis_tuser,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [dsobel_pkg::PIX_W-1:0] m_axis_tdata,
    input wire logic                         m_axis_tlast
);

    import dsobel_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A pixel request keeps the block busy for at least the next cycle.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_DRAIN) |=> !s_axis_tready)
        else $error("pixel request did not occupy the block");

    // A new result only comes out of a busy block.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in progress");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind diagonal_sobel_3x3_edge dsobel_chk u_dsobel_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
